@@ sv/crcsf_pkg.sv @@
// crcsf_pkg: shared types, constants, the crc step and the escape and trailer bytes for the framer
// no dependencies

package crcsf_pkg;

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [7:0]  BYTE_LF   = 8'h0A;
	localparam logic [7:0]  BYTE_CR   = 8'h0D;
	localparam int          JOB_DEPTH = 4;

	// one accepted input item after classification
	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] crc;
		logic        last;
	} job_t;

	// crc-16/ccitt-false, byte-wise shift-xor form
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		begin
			c = {crc[7:0], crc[15:8]};
			c = c ^ {8'h00, b};
			c = c ^ {12'h000, c[7:4]};
			c = c ^ {c[3:0], 12'h000};
			c = c ^ {3'b000, c[7:0], 5'b00000};
			return c;
		end
	endfunction

	// escape prefix bytes: FC FB FA before a line feed, FF FE FD before a carriage return
	function automatic logic [7:0] prefix_byte(input logic is_lf, input logic [1:0] idx);
		logic [7:0] p;
		begin
			case (idx)
				2'd0:    p = is_lf ? 8'hFC : 8'hFF;
				2'd1:    p = is_lf ? 8'hFB : 8'hFE;
				default: p = is_lf ? 8'hFA : 8'hFD;
			endcase
			return p;
		end
	endfunction

	// trailer "MTS" followed by the closing carriage return
	function automatic logic [7:0] trailer_byte(input logic [1:0] idx);
		logic [7:0] t;
		begin
			case (idx)
				2'd0:    t = 8'h4D;
				2'd1:    t = 8'h54;
				2'd2:    t = 8'h53;
				default: t = BYTE_CR;
			endcase
			return t;
		end
	endfunction

endpackage

@@ sv/crcsf_front.sv @@
// crcsf_front: accepts input bytes, runs the crc and builds one job per byte
// depends on crcsf_pkg

module crcsf_front import crcsf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       frame_last,
	input  logic       job_full,
	output logic       job_push,
	output job_t       job
);

	logic [15:0] crc_q;
	logic [15:0] crc_next;

	assign crc_next      = crc_step(crc_q, data_byte);
	assign full          = job_full;
	assign job_push      = push && !job_full;
	assign job.data_byte = data_byte;
	assign job.crc       = crc_next;
	assign job.last      = frame_last;

	// crc restarts once the frame's last byte is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (job_push) begin
			crc_q <= frame_last ? CRC_INIT : crc_next;
		end
	end

endmodule

@@ sv/crcsf_queue.sv @@
// crcsf_queue: short job queue between front and back
// depends on crcsf_pkg

module crcsf_queue import crcsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	input  logic rd_en,
	output job_t rd_job,
	output logic valid
);

	localparam int PtrW = $clog2(JOB_DEPTH);
	localparam int CntW = $clog2(JOB_DEPTH + 1);

	job_t            mem_q [JOB_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full   = (count_q == CntW'(JOB_DEPTH));
	assign valid  = (count_q != '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full || rd_en) else $error("job queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> valid) else $error("job queue read while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !rd_en |=> count_q == $past(count_q) + 1'b1)
		else $error("job count did not advance on write");

endmodule

@@ sv/crcsf_back.sv @@
// crcsf_back: expands each job into escaped output bytes and the frame trailer
// depends on crcsf_pkg

module crcsf_back import crcsf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  job_t       job,
	output logic       job_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_end
);

	typedef enum logic [1:0] {PH_DATA, PH_CRC_LO, PH_CRC_HI, PH_TRAIL} phase_t;

	phase_t     phase_q;
	logic [1:0] sub_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       frame_end_q;

	logic [7:0] cur_byte;
	logic       in_trail;
	logic       need_esc;
	logic       byte_done;
	logic       job_done;
	logic [7:0] emit_byte;
	logic       step;

	assign step = job_valid && (!out_valid_q || pop);

	always_comb begin
		case (phase_q)
			PH_DATA:   cur_byte = job.data_byte;
			PH_CRC_LO: cur_byte = job.crc[7:0];
			PH_CRC_HI: cur_byte = job.crc[15:8];
			default:   cur_byte = trailer_byte(sub_q);
		endcase
		in_trail  = (phase_q == PH_TRAIL);
		need_esc  = !in_trail && (cur_byte == BYTE_LF || cur_byte == BYTE_CR);
		byte_done = !(need_esc && sub_q != 2'd3);
		emit_byte = byte_done ? cur_byte : prefix_byte(cur_byte == BYTE_LF, sub_q);
		job_done  = byte_done && ((phase_q == PH_DATA && !job.last) ||
			(in_trail && sub_q == 2'd3));
	end

	assign job_pop = step && job_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DATA;
			sub_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			run_last_q  <= 1'b0;
			frame_end_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= emit_byte;
				run_last_q  <= job_done;
				frame_end_q <= in_trail && sub_q == 2'd3;
				if (job_done) begin
					phase_q <= PH_DATA;
					sub_q   <= '0;
				end else if (!byte_done || in_trail) begin
					sub_q <= sub_q + 1'b1;
				end else begin
					sub_q <= '0;
					case (phase_q)
						PH_DATA:   phase_q <= PH_CRC_LO;
						PH_CRC_LO: phase_q <= PH_CRC_HI;
						default:   phase_q <= PH_TRAIL;
					endcase
				end
			end
		end
	end

	assign empty     = !out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_end |-> run_last) else $error("frame end without run end");
	a_end_is_cr: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_end |-> out_byte == BYTE_CR) else $error("frame end not a carriage return");
	a_pop_with_step: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> !empty && run_last) else $error("job retired without a closing byte");

endmodule

@@ sv/crc16_byte_stuffing_framer_core.sv @@
// crc16_byte_stuffing_framer_core: top level of the escaping crc framer
// depends on crcsf_pkg, crcsf_front, crcsf_queue, crcsf_back

// Each input byte is taken when full is low; the front end updates the crc-16/ccitt-false
// and queues the byte with its crc in a four-entry job queue. The back end writes one
// output byte per cycle, while pop keeps up, into a single output register, so an input
// byte costs one to four output bytes (one plus three prefixes for an escaped line feed or
// carriage return) and the frame's last byte costs up to sixteen (data, crc low, crc high,
// "MTS", closing carriage return). Sustained input rate follows the back end: one input
// item per cycle for plain data, slower where bytes need escaping.

module crc16_byte_stuffing_framer_core import crcsf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       frame_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_end
);

	job_t wr_job;
	job_t rd_job;
	logic job_push;
	logic job_full;
	logic job_pop;
	logic job_valid;

	crcsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.frame_last (frame_last),
		.job_full   (job_full),
		.job_push   (job_push),
		.job        (wr_job)
	);

	crcsf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (wr_job),
		.full   (job_full),
		.rd_en  (job_pop),
		.rd_job (rd_job),
		.valid  (job_valid)
	);

	crcsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (rd_job),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.frame_end (frame_end)
	);

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// testbench: checks crc16_byte_stuffing_framer_core against its own crc and escaping predictor
// depends on crcsf_pkg and the framer rtl

module testbench;
	import crcsf_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RANDOM_ITEMS   = 160;
	localparam int HOLD_AT_COUNT  = 120;
	localparam int HOLD_CYCLES    = 200;
	localparam int N_ROWS         = 21;

	localparam logic [7:0] LF_PRE0 = 8'hFC, LF_PRE1 = 8'hFB, LF_PRE2 = 8'hFA;
	localparam logic [7:0] CR_PRE0 = 8'hFF, CR_PRE1 = 8'hFE, CR_PRE2 = 8'hFD;
	localparam logic [7:0] TRL_M = 8'h4D, TRL_T = 8'h54, TRL_S = 8'h53;

	typedef struct packed {
		logic [7:0] val;
		logic       run_last;
		logic       frame_end;
	} tx_byte_t;

	// n_lit > 0: expected bytes typed in, first byte in the highest of the n_lit low bytes of lit
	typedef struct packed {
		logic [7:0]  b;
		logic        last;
		logic [2:0]  n_lit;
		logic [31:0] lit;
	} row_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] data_byte;
	logic       frame_last;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_end;

	logic [15:0] frame_crc;
	tx_byte_t    tx_due[$];
	int          n_errors;
	int          rx_count;
	int          stall_cycles;
	bit          tx_steady;

	row_t dir_rows [N_ROWS] = '{
		'{8'h00, 1'b0, 3'd1, 32'h0000_0000},
		'{8'hFF, 1'b0, 3'd1, 32'h0000_00FF},
		'{8'h0A, 1'b0, 3'd4, 32'hFCFB_FA0A},
		'{8'h0D, 1'b0, 3'd4, 32'hFFFE_FD0D},
		'{8'h80, 1'b1, 3'd0, 32'h0},
		// single-byte frames, including escaped ones
		'{8'h0A, 1'b1, 3'd0, 32'h0},
		'{8'h0D, 1'b1, 3'd0, 32'h0},
		'{8'h00, 1'b1, 3'd0, 32'h0},
		'{8'hFF, 1'b1, 3'd0, 32'h0},
		// neighbours of the escaped values and the prefix bytes pass through
		'{8'h0B, 1'b0, 3'd1, 32'h0000_000B},
		'{8'h09, 1'b0, 3'd1, 32'h0000_0009},
		'{8'h0C, 1'b0, 3'd1, 32'h0000_000C},
		'{8'h0E, 1'b0, 3'd1, 32'h0000_000E},
		'{8'hFC, 1'b0, 3'd1, 32'h0000_00FC},
		'{8'hFD, 1'b0, 3'd1, 32'h0000_00FD},
		'{8'hFE, 1'b0, 3'd1, 32'h0000_00FE},
		'{8'h0A, 1'b0, 3'd4, 32'hFCFB_FA0A},
		'{8'h0A, 1'b0, 3'd4, 32'hFCFB_FA0A},
		'{8'h0D, 1'b0, 3'd4, 32'hFFFE_FD0D},
		'{8'h7F, 1'b1, 3'd0, 32'h0},
		'{8'h01, 1'b1, 3'd0, 32'h0}
	};

	crc16_byte_stuffing_framer_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.frame_last (frame_last),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.frame_end  (frame_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bit-serial crc-16/ccitt-false, msb first, poly 0x1021
	function automatic logic [15:0] ccitt_next(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
		return r;
	endfunction

	task automatic due_raw(input logic [7:0] v, input logic fe);
		tx_due.push_back('{v, 1'b0, fe});
	endtask

	task automatic due_escaped(input logic [7:0] v);
		if (v == BYTE_LF) begin
			due_raw(LF_PRE0, 1'b0);
			due_raw(LF_PRE1, 1'b0);
			due_raw(LF_PRE2, 1'b0);
		end
		if (v == BYTE_CR) begin
			due_raw(CR_PRE0, 1'b0);
			due_raw(CR_PRE1, 1'b0);
			due_raw(CR_PRE2, 1'b0);
		end
		due_raw(v, 1'b0);
	endtask

	// escaped stream for one byte, plus crc and trailer when it closes the frame
	task automatic frame_byte_out(input logic [7:0] b, input logic last);
		tx_byte_t t;
		frame_crc = ccitt_next(frame_crc, b);
		due_escaped(b);
		if (last) begin
			due_escaped(frame_crc[7:0]);
			due_escaped(frame_crc[15:8]);
			due_raw(TRL_M, 1'b0);
			due_raw(TRL_T, 1'b0);
			due_raw(TRL_S, 1'b0);
			due_raw(BYTE_CR, 1'b1);
			frame_crc = CRC_INIT;
		end
		t = tx_due.pop_back();
		t.run_last = 1'b1;
		tx_due.push_back(t);
	endtask

	function automatic int idle_len(input bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [7:0] payload_byte();
		int r;
		r = $urandom_range(99);
		if (r < 12)
			return BYTE_LF;
		if (r < 24)
			return BYTE_CR;
		if (r < 32)
			return 8'($urandom_range(255, 248));
		return 8'($urandom_range(255));
	endfunction

	// often pick the closing byte so that a crc byte itself needs escaping
	function automatic logic [7:0] closing_byte(input logic [15:0] crc);
		int off;
		logic [15:0] nxt;
		logic [7:0] tgt;
		logic [7:0] c;
		bit hi;
		if ($urandom_range(99) >= 35)
			return payload_byte();
		off = $urandom_range(255);
		tgt = $urandom_range(1) ? BYTE_LF : BYTE_CR;
		hi = 1'($urandom_range(1));
		for (int k = 0; k < 256; k++) begin
			c = 8'(off + k);
			nxt = ccitt_next(crc, c);
			if ((hi ? nxt[15:8] : nxt[7:0]) == tgt)
				return c;
		end
		return payload_byte();
	endfunction

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic offer(input logic [7:0] b, input logic last, input logic [2:0] n_lit,
			input logic [31:0] lit);
		int g;
		if ($urandom_range(31) == 0)
			tx_steady = !tx_steady;
		g = idle_len(tx_steady);
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(negedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		frame_last <= last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (n_lit != 0) begin
			frame_crc = ccitt_next(frame_crc, b);
			for (int k = n_lit - 1; k >= 0; k--)
				tx_due.push_back('{lit[8*k +: 8], (k == 0), 1'b0});
		end else begin
			frame_byte_out(b, last);
		end
		@(negedge clk);
	endtask

	task automatic pause_until_drained();
		push <= 1'b0;
		while (tx_due.size() != 0)
			@(negedge clk);
	endtask

	// result side: check every popped transaction against the oldest expectation
	always @(posedge clk) begin
		tx_byte_t e;
		if (arst_n && pop && !empty) begin
			rx_count++;
			if (tx_due.size() == 0) begin
				$error("unexpected result: out_byte %h run_last %b frame_end %b",
					out_byte, run_last, frame_end);
				n_errors++;
			end else begin
				e = tx_due.pop_front();
				if (out_byte !== e.val) begin
					$error("out_byte: expected %h, got %h", e.val, out_byte);
					n_errors++;
				end
				if (run_last !== e.run_last) begin
					$error("run_last: expected %b, got %b", e.run_last, run_last);
					n_errors++;
				end
				if (frame_end !== e.frame_end) begin
					$error("frame_end: expected %b, got %b", e.frame_end, frame_end);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// receiver: random gaps, plus one long hold-off so the input side backs up
	initial begin
		int idle;
		int hold;
		bit steady;
		bit held;
		idle = 0;
		hold = 0;
		steady = 0;
		held = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && rx_count >= HOLD_AT_COUNT) begin
				held = 1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else if (idle > 0) begin
				idle--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(63) == 0)
					steady = !steady;
				idle = idle_len(steady);
			end
		end
	end

	initial begin
		int sent;
		int flen;
		bit paused;
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = 8'h00;
		frame_last = 1'b0;
		frame_crc = CRC_INIT;
		n_errors = 0;
		rx_count = 0;
		stall_cycles = 0;
		tx_steady = 0;
		sent = 0;
		paused = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].b, dir_rows[i].last, dir_rows[i].n_lit, dir_rows[i].lit);
		pause_until_drained();

		// whole frames with random content and length, a few long ones
		while (sent < RANDOM_ITEMS) begin
			flen = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
			for (int k = 1; k < flen; k++)
				offer(payload_byte(), 1'b0, 3'd0, 32'h0);
			offer(closing_byte(frame_crc), 1'b1, 3'd0, 32'h0);
			sent += flen;
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				paused = 1;
				pause_until_drained();
			end
		end
		push <= 1'b0;

		while (tx_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tx_due.size() != 0) begin
			$error("%0d expected results never arrived", tx_due.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
sv/crcsf_pkg.sv
sv/crcsf_front.sv
sv/crcsf_queue.sv
sv/crcsf_back.sv
sv/crc16_byte_stuffing_framer_core.sv
test/testbench.sv
